/* rtl/core/graham_scan_convex_hull_defines.svh */
// Assertion macros shared by the hull core
`ifndef GRAHAM_SCAN_CONVEX_HULL_DEFINES_SVH
`define GRAHAM_SCAN_CONVEX_HULL_DEFINES_SVH
`define GSCH_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define GSCH_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* rtl/core/gsch_pkg.sv */
`default_nettype none
package gsch_pkg;
  localparam int CoordW = 16;
  localparam int PointW = 2 * CoordW;
  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusDegen  = 2'd1;
  localparam logic [1:0] StatusOvflow = 2'd2;
  typedef logic signed [CoordW-1:0] coord_t;
  typedef struct packed {
    coord_t y;
    coord_t x;
  } point_t;
  // cross-product operands are 17 bit, products 34 bit
  typedef logic signed [CoordW:0] diff_t;
  typedef logic signed [2*CoordW+1:0] prod_t;
  typedef logic signed [2*CoordW+2:0] cross_t;
endpackage
`default_nettype wire

/* rtl/core/gsch_ram.sv */
`default_nettype none
module gsch_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/core/gsch_cross.sv */
`default_nettype none
// Cross product (a-o)x(b-o): products registered, then subtracted.
module gsch_cross (
  input  wire logic            clk,
  input  wire gsch_pkg::point_t o,
  input  wire gsch_pkg::point_t a,
  input  wire gsch_pkg::point_t b,
  output gsch_pkg::cross_t     xprod
);
  import gsch_pkg::*;
  diff_t ax, ay, bx, by;
  prod_t p1, p2;
  always_comb begin
    ax = diff_t'(a.x) - diff_t'(o.x);
    ay = diff_t'(a.y) - diff_t'(o.y);
    bx = diff_t'(b.x) - diff_t'(o.x);
    by = diff_t'(b.y) - diff_t'(o.y);
  end
  always_ff @(posedge clk) begin
    p1 <= prod_t'(ax) * prod_t'(by);
    p2 <= prod_t'(ay) * prod_t'(bx);
  end
  assign xprod = cross_t'(p1) - cross_t'(p2);
endmodule
`default_nettype wire

/* rtl/core/graham_scan_convex_hull.sv */
`default_nettype none
// Load: one point per cycle, busy stays low between points of a set.
// On the last point: lowest-point search and swap, insertion sort (O(n^2) worst case),
// prune, scan with a pop or push per step, then the hull vertices one by one on the
// strobe, with no new set taken until the last vertex is out.
// The single-read-port point memory sets the pace. Receiver cannot stall.
// Synchronous reset clears point count, stack depth, orientation, outputs and control.
module graham_scan_convex_hull #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic signed [15:0]   x_coord,
  input  wire logic signed [15:0]   y_coord,
  input  wire logic                 last_point,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_wdata,
  output logic                      strobe,
  output logic signed [15:0]        hull_x,
  output logic signed [15:0]        hull_y,
  output logic [1:0]                status,
  output logic                      last_vertex
);
  import gsch_pkg::*;
  `include "graham_scan_convex_hull_defines.svh"

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [4:0] S_IDLE = 5'd0,  S_MINR = 5'd1,  S_MINW = 5'd2,
                         S_SW0 = 5'd3,   S_SW1 = 5'd4,   S_SW2 = 5'd5,
                         S_SOI = 5'd6,   S_SOR = 5'd7,   S_SOW = 5'd8,
                         S_SOC = 5'd9,   S_SOC2 = 5'd10, S_SOD = 5'd11,
                         S_PRI = 5'd12,  S_PRR = 5'd13,  S_PRW = 5'd14,
                         S_PRC = 5'd15,  S_PRD = 5'd16,  S_SCI = 5'd17,
                         S_SCR = 5'd18,  S_SCW = 5'd19,  S_SCC = 5'd20,
                         S_SCD = 5'd21,  S_OUT = 5'd22,  S_OUR = 5'd23,
                         S_OUW = 5'd24,  S_OUE = 5'd25,  S_PRL = 5'd26,
                         S_SCE = 5'd27;

  logic [4:0]    state;
  logic          orientation;
  logic [CW-1:0] point_count;
  logic          overflow_seen;
  logic [CW-1:0] stack_depth;
  point_t        start_point;

  // point memory
  logic          pm_we;
  logic [AW-1:0] pm_waddr, pm_raddr;
  point_t        pm_wdata, pm_rdata;
  gsch_ram #(.Width(PointW), .Depth(MAX_POINTS)) u_points (
    .clk, .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(pm_raddr), .rdata(pm_rdata)
  );
  // stack memory of indexes
  logic          st_we;
  logic [AW-1:0] st_waddr, st_raddr, st_wdata, st_rdata;
  gsch_ram #(.Width(AW), .Depth(MAX_POINTS)) u_stack (
    .clk, .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  // working registers
  logic [CW-1:0] n, i, j, m;
  logic [AW-1:0] lo;
  point_t        pa, pb, pc, tpt;
  logic [1:0]    stat;
  logic [CW-1:0] k;

  point_t cx_o, cx_a, cx_b;
  cross_t xprod;
  gsch_cross u_cross (.clk, .o(cx_o), .a(cx_a), .b(cx_b), .xprod(xprod));

  // goes_before(tpt, pa) about start_point, given cross(start,tpt,pa)
  function automatic logic [2*CoordW+2:0] d2(input point_t a, input point_t s);
    logic signed [CoordW:0] dx, dy;
    dx = diff_t'(a.x) - diff_t'(s.x);
    dy = diff_t'(a.y) - diff_t'(s.y);
    return (2*CoordW+3)'(dx * dx) + (2*CoordW+3)'(dy * dy);
  endfunction
  logic [2*CoordW+2:0] da, db;
  logic goes_first;
  // distances registered alongside the cross product, from the same operands
  always_ff @(posedge clk) begin
    da <= d2(cx_a, cx_o);
    db <= d2(cx_b, cx_o);
  end
  always_comb begin
    if (da == '0) goes_first = (db != '0);
    else if (db == '0) goes_first = 1'b0;
    else if (xprod > 0) goes_first = 1'b1;
    else if (xprod < 0) goes_first = 1'b0;
    else goes_first = (da < db);
  end

  wire accept = start && !busy;
  wire lower = (pm_rdata.y < pa.y) || (pm_rdata.y == pa.y && pm_rdata.x < pa.x);
  assign busy = (state != S_IDLE);

  always_comb begin
    pm_we = 1'b0; pm_waddr = '0; pm_wdata = tpt; pm_raddr = '0;
    st_we = 1'b0; st_waddr = '0; st_wdata = '0; st_raddr = '0;
    cx_o = start_point; cx_a = tpt; cx_b = pa;
    unique case (state)
      S_IDLE: begin
        pm_we = accept && (point_count < CW'(MAX_POINTS));
        pm_waddr = AW'(point_count);
        pm_wdata = '{y: y_coord, x: x_coord};
      end
      S_MINR, S_MINW: pm_raddr = AW'(i);
      S_SW0: pm_raddr = '0;
      S_SW1: begin pm_we = 1'b1; pm_waddr = lo; pm_wdata = pm_rdata; end
      S_SW2: begin pm_we = 1'b1; pm_waddr = '0; pm_wdata = pa; end
      S_SOI, S_SOR: pm_raddr = AW'(i);
      S_SOW: pm_raddr = AW'(j - 1'b1);
      S_SOC: begin pm_raddr = AW'(j - 1'b1); cx_b = pm_rdata; end
      S_SOC2: begin
        if (goes_first) begin pm_we = 1'b1; pm_waddr = AW'(j); pm_wdata = pa; end
        else begin pm_we = 1'b1; pm_waddr = AW'(j); pm_wdata = tpt; end
      end
      S_SOD: begin pm_we = 1'b1; pm_waddr = AW'(j); pm_wdata = tpt; end
      S_PRI: pm_raddr = AW'(i);
      S_PRL, S_PRR: pm_raddr = AW'(i + 1'b1);
      S_PRW: begin cx_a = pa; cx_b = pm_rdata; end
      S_PRC: begin cx_a = pa; cx_b = pb; end
      S_PRD: begin pm_we = 1'b1; pm_waddr = AW'(m); pm_wdata = pa; end
      S_SCI: begin
        st_we = 1'b1; st_waddr = AW'(k); st_wdata = AW'(k);
      end
      S_SCR: begin st_raddr = AW'(stack_depth - 2'd2); pm_raddr = AW'(i); end
      S_SCW: begin st_raddr = AW'(stack_depth - 1'b1); pm_raddr = st_rdata; end
      S_SCC: pm_raddr = st_rdata;
      S_SCD: begin cx_o = pa; cx_a = pm_rdata; cx_b = pc; end
      S_SCE: begin
        if (!(stack_depth >= CW'(2) && xprod <= 0)) begin
          st_we = 1'b1; st_waddr = AW'(stack_depth); st_wdata = AW'(i);
        end
      end
      S_OUT: st_raddr = (orientation && k != '0) ? AW'(stack_depth - k) : AW'(k);
      S_OUR: pm_raddr = st_rdata;
      S_OUW, S_OUE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    if (rst) begin
      state <= S_IDLE; orientation <= 1'b0; point_count <= '0;
      overflow_seen <= 1'b0; stack_depth <= '0; start_point <= '0;
      last_vertex <= 1'b0; status <= StatusOk; hull_x <= '0; hull_y <= '0;
    end else begin
      if (cfg_we) orientation <= cfg_wdata;
      unique case (state)
        S_IDLE: if (accept) begin
          if (point_count < CW'(MAX_POINTS)) point_count <= point_count + 1'b1;
          else overflow_seen <= 1'b1;
          if (last_point) begin
            n <= (point_count < CW'(MAX_POINTS)) ? point_count + 1'b1 : point_count;
            i <= '0; lo <= '0;
            state <= S_MINR;
          end
        end
        S_MINR: begin i <= i + 1'b1; state <= S_MINW; end
        S_MINW: begin
          // pm_rdata holds point i-1
          if (i == CW'(1)) pa <= pm_rdata;
          else if (lower) begin pa <= pm_rdata; lo <= AW'(i - 1'b1); end
          if (i == n) state <= S_SW0;
          else i <= i + 1'b1;
          if (i == n) i <= '0;
        end
        S_SW0: state <= S_SW1; // pm_rdata = point 0 next cycle
        S_SW1: begin tpt <= pm_rdata; state <= S_SW2; end
        S_SW2: begin start_point <= pa; i <= CW'(2); state <= S_SOI; end
        S_SOI: begin
          if (i < n) state <= S_SOR;
          else begin i <= CW'(1); m <= CW'(1); state <= S_PRI; end
        end
        S_SOR: begin tpt <= pm_rdata; j <= i; state <= S_SOW; end
        S_SOW: state <= (j > CW'(1)) ? S_SOC : S_SOD;
        S_SOC: begin pa <= pm_rdata; state <= S_SOC2 + 5'd0; end
        S_SOC2: begin
          if (goes_first) begin j <= j - 1'b1; state <= S_SOW; end
          else begin i <= i + 1'b1; state <= S_SOI; end
        end
        S_SOD: begin i <= i + 1'b1; state <= S_SOI; end
        S_PRI: state <= S_PRL;
        S_PRL: begin
          pa <= pm_rdata;
          if (i >= n) begin k <= '0; state <= S_SCI; end
          else state <= S_PRW;
        end
        S_PRR: begin
          if (i >= n) begin k <= '0; state <= S_SCI; end
          else state <= S_PRW;
        end
        S_PRW: begin pb <= pm_rdata; state <= S_PRC; end
        S_PRC: begin
          if (i + 1'b1 < n && xprod == 0) begin i <= i + 1'b1; pa <= pb; state <= S_PRR; end
          else state <= S_PRD;
        end
        S_PRD: begin m <= m + 1'b1; i <= i + 1'b1; pa <= pb; state <= S_PRR; end
        S_SCI: begin
          if (k + 1'b1 >= ((m < CW'(3)) ? m : CW'(3))) begin
            stack_depth <= (m < CW'(3)) ? m : CW'(3);
            i <= CW'(3); k <= '0;
            stat <= (m < CW'(3)) ? StatusDegen : (overflow_seen ? StatusOvflow : StatusOk);
            state <= (m < CW'(3)) ? S_OUT : S_SCR;
          end else k <= k + 1'b1;
        end
        S_SCR: state <= (i < m) ? S_SCW : S_OUT;
        S_SCW: begin pc <= pm_rdata; state <= S_SCC; end
        S_SCC: begin pa <= pm_rdata; state <= S_SCD; end
        // turn-test operands applied here, products registered and decided in the next cycle
        S_SCD: state <= S_SCE;
        S_SCE: begin
          if (stack_depth >= CW'(2) && xprod <= 0) begin
            stack_depth <= stack_depth - 1'b1; state <= S_SCR;
          end else begin
            stack_depth <= stack_depth + 1'b1; i <= i + 1'b1; state <= S_SCR;
          end
        end
        S_OUT: state <= S_OUR;
        S_OUR: state <= S_OUW;
        S_OUW: begin
          strobe <= 1'b1; hull_x <= pm_rdata.x; hull_y <= pm_rdata.y;
          status <= stat; last_vertex <= (k + 1'b1 == stack_depth);
          if (k + 1'b1 == stack_depth) state <= S_OUE;
          else begin k <= k + 1'b1; state <= S_OUT; end
        end
        S_OUE: begin
          point_count <= '0; stack_depth <= '0; overflow_seen <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GSCH_ASSERT(a_no_start_busy, clk, rst, strobe |-> busy, "strobe while idle")
  `GSCH_ASSERT(a_count_range, clk, rst, point_count <= CW'(MAX_POINTS), "count over capacity")
  `GSCH_ASSERT(a_last_end, clk, rst, (strobe && last_vertex) |=> !strobe, "strobe after last vertex")
endmodule
`default_nettype wire

/* dv/tb.sv */
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsch_pkg::*;

  localparam int Depth = 64;
  localparam int IdleLimit = 400000;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } vert_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [1:0] st;
    logic lastv;
  } vertex_t;

  class hull_board;
    vert_t pts[$];
    bit ovf;
    bit orient;
    vertex_t hull_q[$];
    int errors;
    int vertices_seen;
    int hulls;

    function longint turn_of(vert_t o, vert_t a, vert_t b);
      longint ax, ay, bx, by;
      ax = longint'(a.x) - o.x;
      ay = longint'(a.y) - o.y;
      bx = longint'(b.x) - o.x;
      by = longint'(b.y) - o.y;
      return ax * by - ay * bx;
    endfunction

    function longint dsq(vert_t a, vert_t b);
      longint dx, dy;
      dx = longint'(a.x) - b.x;
      dy = longint'(a.y) - b.y;
      return dx * dx + dy * dy;
    endfunction

    function bit ahead(vert_t a, vert_t b, vert_t s);
      longint da, db, c;
      da = dsq(s, a);
      db = dsq(s, b);
      if (da == 0) return db != 0;
      if (db == 0) return 0;
      c = turn_of(s, a, b);
      if (c != 0) return c > 0;
      return da < db;
    endfunction

    function void note_point(logic signed [15:0] x, logic signed [15:0] y, bit lastp);
      vert_t p, t, s;
      vert_t a[$];
      int n, lo, j, m, sp;
      int stk[$];
      logic [1:0] st;
      vertex_t v;
      p.x = x;
      p.y = y;
      if (pts.size() < Depth) pts = {pts, p};
      else ovf = 1;
      if (!lastp) return;
      a = pts;
      n = a.size();
      lo = 0;
      for (int i = 1; i < n; i++)
        if (a[i].y < a[lo].y || (a[i].y == a[lo].y && a[i].x < a[lo].x)) lo = i;
      t = a[0]; a[0] = a[lo]; a[lo] = t;
      s = a[0];
      for (int i = 2; i < n; i++) begin
        t = a[i];
        j = i;
        while (j > 1 && ahead(t, a[j-1], s)) begin
          a[j] = a[j-1];
          j--;
        end
        a[j] = t;
      end
      m = 1;
      for (int i = 1; i < n; i++) begin
        while (i + 1 < n && turn_of(s, a[i], a[i+1]) == 0) i++;
        a[m] = a[i];
        m++;
      end
      if (m < 3) begin
        for (int i = 0; i < m; i++) stk = {stk, i};
        st = StatusDegen;
      end else begin
        stk = '{0, 1, 2};
        for (int i = 3; i < m; i++) begin
          while (stk.size() >= 2 &&
                 turn_of(a[stk[stk.size()-2]], a[stk[stk.size()-1]], a[i]) <= 0)
            stk = stk[0:$-1];
          stk = {stk, i};
        end
        st = ovf ? StatusOvflow : StatusOk;
      end
      sp = stk.size();
      for (int k = 0; k < sp; k++) begin
        j = (orient && k != 0) ? sp - k : k;
        v.x = a[stk[j]].x;
        v.y = a[stk[j]].y;
        v.st = st;
        v.lastv = (k + 1 == sp);
        hull_q = {hull_q, v};
      end
      pts.delete();
      ovf = 0;
      hulls++;
    endfunction

    function void check_vertex(vertex_t got);
      vertex_t e;
      vertices_seen++;
      if (hull_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected vertex x=%0d y=%0d", got.x, got.y);
        return;
      end
      e = hull_q.pop_front();
      if (e.x !== got.x || e.y !== got.y || e.st !== got.st || e.lastv !== got.lastv) begin
        errors++;
        if (errors <= 10)
          $display("vertex mismatch: exp (%0d,%0d) st=%0d l=%0d got (%0d,%0d) st=%0d l=%0d",
                   e.x, e.y, e.st, e.lastv, got.x, got.y, got.st, got.lastv);
      end
    endfunction
  endclass

  logic clk, rst, start, busy, last_point, cfg_we, cfg_wdata;
  logic signed [15:0] x_coord, y_coord;
  logic strobe, last_vertex;
  logic signed [15:0] hull_x, hull_y;
  logic [1:0] status;

  hull_board sb;
  int idle_cycles;
  int sent;

  graham_scan_convex_hull dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_coord(x_coord), .y_coord(y_coord), .last_point(last_point),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .strobe(strobe),
    .hull_x(hull_x), .hull_y(hull_y), .status(status), .last_vertex(last_vertex)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    vertex_t g;
    if (!rst && strobe) begin
      g.x = hull_x;
      g.y = hull_y;
      g.st = status;
      g.lastv = last_vertex;
      sb.check_vertex(g);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("watchdog: no progress");
      $display("graham_scan_convex_hull: mismatch");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    return (r < 92) ? int'($urandom_range(1, 3)) : int'($urandom_range(8, 40));
  endfunction

  // start stays high into the next transaction when there is no gap
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit lastp);
    int g;
    start <= 1;
    x_coord <= x;
    y_coord <= y;
    last_point <= lastp;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_point(x, y, lastp);
    sent++;
    g = gap_len();
    if (g > 0) begin
      start <= 0;
      x_coord <= 16'($urandom);
      y_coord <= 16'($urandom);
      last_point <= 1'($urandom);
      repeat (g) @(posedge clk);
    end
  endtask

  // wait out the hull pipeline, then a margin for the quiet tail
  task automatic drain();
    start <= 0;
    while (sb.hull_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_orient(bit v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.orient = v;
  endtask

  function automatic logic signed [15:0] coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  task automatic random_set(int n, int mode);
    for (int i = 0; i < n; i++)
      send_point(coord(mode), coord(mode), i == n - 1);
  endtask

  initial begin
    int n;
    sb = new();
    rst = 1; start = 0; x_coord = 0; y_coord = 0; last_point = 0;
    cfg_we = 0; cfg_wdata = 0; sent = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // extremes of the coordinate range, square hull
    send_point(-32768, -32768, 0);
    send_point(32767, -32768, 0);
    send_point(32767, 32767, 0);
    send_point(-32768, 32767, 0);
    send_point(0, 0, 1);
    // single point, then two: degenerate
    send_point(5, 5, 1);
    send_point(1, 2, 0);
    send_point(3, 4, 1);
    // collinear and duplicates of the start
    send_point(0, 0, 0);
    send_point(0, 0, 0);
    send_point(1, 1, 0);
    send_point(2, 2, 0);
    send_point(3, 3, 1);
    set_orient(1);
    send_point(0, 0, 0);
    send_point(4, 0, 0);
    send_point(4, 4, 0);
    send_point(2, 1, 0);
    send_point(0, 4, 1);
    // overflow: 70 points, last mark on a dropped one
    set_orient(0);
    random_set(70, 2);
    set_orient(1);
    random_set(66, 1);

    while (sent < 480) begin
      if ($urandom_range(0, 9) == 0) set_orient(1'($urandom));
      n = $urandom_range(0, 19) == 0 ? $urandom_range(60, 68) : $urandom_range(1, 12);
      random_set(n, $urandom_range(0, 2));
    end
    drain();
    $display("ran %0d points in %0d sets, %0d hull vertices checked",
             sent, sb.hulls, sb.vertices_seen);
    if (sb.errors == 0) $display("graham_scan_convex_hull: match");
    else $display("graham_scan_convex_hull: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/gsch_pkg.sv
rtl/core/gsch_ram.sv
rtl/core/gsch_cross.sv
rtl/core/graham_scan_convex_hull.sv
dv/tb.sv
